[hdl/uvlt_pkg.sv]
package uvlt_pkg;

  localparam logic [7:0]  BYTE_NUL = 8'h00;
  localparam logic [7:0]  BYTE_LF  = 8'h0a;
  localparam logic [7:0]  BYTE_CR  = 8'h0d;
  localparam logic [7:0]  LEAD2_LO = 8'hc2;
  localparam logic [7:0]  LEAD2_HI = 8'hdf;
  localparam logic [7:0]  LEAD3_LO = 8'he0;
  localparam logic [7:0]  LEAD3_HI = 8'hef;
  localparam logic [7:0]  LEAD4_LO = 8'hf0;
  localparam logic [7:0]  LEAD4_HI = 8'hf4;

  localparam logic [20:0] CP_MIN2  = 21'h000080;
  localparam logic [20:0] CP_MIN3  = 21'h000800;
  localparam logic [20:0] CP_MIN4  = 21'h010000;
  localparam logic [20:0] CP_MAX   = 21'h10ffff;
  localparam logic [20:0] SURR_LO  = 21'h00d800;
  localparam logic [20:0] SURR_HI  = 21'h00dfff;

  localparam logic [23:0] SAT24       = 24'hffffff;
  localparam logic [19:0] LIMIT_RESET = 20'd4096;

  typedef enum logic [1:0] {
    EV_NUL  = 2'd0,
    EV_BAD  = 2'd1,
    EV_LONG = 2'd2,
    EV_END  = 2'd3
  } uvlt_event_t;

  // queued item with its byte class
  typedef struct packed {
    logic [7:0] data;
    logic       eot;
    logic       is_cr;
    logic       is_lf;
    logic       is_nul;
    logic       is_ascii;
    logic       is_cont;
    logic [2:0] lead_len;
    logic [4:0] lead_bits;
  } uvlt_item_t;

  typedef struct packed {
    uvlt_event_t ev;
    logic [31:0] offset;
    logic [23:0] line;
    logic [23:0] col;
    logic        last;
  } uvlt_res_t;

endpackage

[hdl/uvlt_front.sv]
module uvlt_front #(
  parameter int DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,
  input  logic                 in_tlast,
  output logic                 head_valid,
  output uvlt_pkg::uvlt_item_t head,
  input  logic                 head_pop
);
  import uvlt_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  uvlt_item_t      q_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            push;

  function automatic uvlt_item_t classify(input logic [7:0] b, input logic eot);
    uvlt_item_t it;
    it.data     = b;
    it.eot      = eot;
    it.is_cr    = (b == BYTE_CR);
    it.is_lf    = (b == BYTE_LF);
    it.is_nul   = (b == BYTE_NUL);
    it.is_ascii = ~b[7];
    it.is_cont  = (b[7:6] == 2'b10);
    priority if (b >= LEAD2_LO && b <= LEAD2_HI) begin
      it.lead_len  = 3'd2;
      it.lead_bits = b[4:0];
    end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
      it.lead_len  = 3'd3;
      it.lead_bits = {1'b0, b[3:0]};
    end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
      it.lead_len  = 3'd4;
      it.lead_bits = {2'b00, b[2:0]};
    end else begin
      it.lead_len  = 3'd0;
      it.lead_bits = 5'd0;
    end
    return it;
  endfunction

  assign in_tready  = (cnt_r != CW'(DEPTH));
  assign push       = in_tvalid && in_tready;
  assign head_valid = (cnt_r != '0);
  assign head       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (head_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    cnt_nxt = cnt_r + CW'(push) - CW'(head_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= classify(in_tdata, in_tlast);
    end
  end

endmodule

[hdl/uvlt_back.sv]
module uvlt_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 head_valid,
  input  uvlt_pkg::uvlt_item_t head,
  output logic                 head_pop,
  input  logic [19:0]          limit,
  output logic                 res_valid,
  input  logic                 res_ready,
  output uvlt_pkg::uvlt_res_t  res
);
  import uvlt_pkg::*;

  typedef enum logic [6:0] {
    PH_BYTE = 7'b0000001,
    PH_CR   = 7'b0000010,
    PH_NEW  = 7'b0000100,
    PH_REPL = 7'b0001000,
    PH_ECR  = 7'b0010000,
    PH_EFL  = 7'b0100000,
    PH_END  = 7'b1000000
  } uvlt_phase_t;

  uvlt_phase_t phase_r, phase_nxt;
  logic        cr_r, cr_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [2:0]  len_r, len_nxt;
  logic [20:0] cp_r, cp_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [23:0] line_r, line_nxt;
  logic [23:0] col_r, col_nxt;
  logic [19:0] fill_r, fill_nxt;
  logic        stop_r, stop_nxt;
  logic [1:0]  rep_r, rep_nxt;
  logic        ret_new_r, ret_new_nxt;

  logic        pend_valid_r, pend_final_r;
  uvlt_res_t   pend_r;
  logic        out_valid_r;
  uvlt_res_t   out_r;

  logic        emit, final_step, go_tail;
  logic        do_new, do_fail, do_consume, do_halt;
  logic [1:0]  fail_n;
  uvlt_event_t ev_code;
  logic [31:0] ev_off;
  logic        fill_ge, cp_bad, seq_long;
  logic [20:0] cont_cp, cp_min;
  logic [2:0]  cnt_inc;
  logic [23:0] col_bump;
  uvlt_res_t   cur_res, out_d;
  logic        flush, step_en, need_push, out_free, commit, load_out;

  assign fill_ge  = (fill_r >= limit);
  assign cont_cp  = {cp_r[14:0], head.data[5:0]};
  assign cnt_inc  = cnt_r + 3'd1;
  assign col_bump = (col_r != SAT24) ? col_r + 24'd1 : col_r;
  assign seq_long = ({1'b0, fill_r} + {18'd0, len_r}) > {1'b0, limit};

  always_comb begin
    unique case (len_r)
      3'd2:    cp_min = CP_MIN2;
      3'd3:    cp_min = CP_MIN3;
      default: cp_min = CP_MIN4;
    endcase
    cp_bad = (cont_cp < cp_min) || (cont_cp > CP_MAX) ||
             ((cont_cp >= SURR_LO) && (cont_cp <= SURR_HI));
  end

  always_comb begin
    phase_nxt   = phase_r;
    cr_nxt      = cr_r;
    cnt_nxt     = cnt_r;
    len_nxt     = len_r;
    cp_nxt      = cp_r;
    pos_nxt     = pos_r;
    line_nxt    = line_r;
    col_nxt     = col_r;
    fill_nxt    = fill_r;
    stop_nxt    = stop_r;
    rep_nxt     = rep_r;
    ret_new_nxt = ret_new_r;
    emit        = 1'b0;
    ev_code     = EV_NUL;
    ev_off      = pos_r;
    final_step  = 1'b0;
    go_tail     = 1'b0;
    do_new      = 1'b0;
    do_fail     = 1'b0;
    do_consume  = 1'b0;
    do_halt     = 1'b0;
    fail_n      = 2'd0;

    unique case (phase_r)
      PH_CR: begin
        cr_nxt = 1'b0;
        if (!head.is_lf && fill_ge) begin
          do_halt = 1'b1;
          go_tail = 1'b1;
        end else begin
          if (head.is_lf) begin
            pos_nxt = pos_r + 32'd1;
            col_nxt = col_bump;
          end else begin
            do_consume = 1'b1;
          end
          phase_nxt = PH_BYTE;
        end
      end
      PH_BYTE: begin
        if (stop_r) begin
          go_tail = 1'b1;
        end else if (cnt_r != 3'd0 && head.is_cont) begin
          cnt_nxt = cnt_inc;
          cp_nxt  = cont_cp;
          if (cnt_inc >= len_r) begin
            if (cp_bad) begin
              do_fail     = 1'b1;
              fail_n      = cnt_r[1:0];
              ret_new_nxt = 1'b0;
            end else if (seq_long) begin
              do_halt = 1'b1;
              go_tail = 1'b1;
            end else begin
              pos_nxt  = pos_r + {29'd0, len_r};
              col_nxt  = col_bump;
              fill_nxt = fill_r + {17'd0, len_r};
              cnt_nxt  = 3'd0;
              len_nxt  = 3'd0;
              cp_nxt   = 21'd0;
              go_tail  = 1'b1;
            end
          end else begin
            go_tail = 1'b1;
          end
        end else if (cnt_r != 3'd0) begin
          do_fail     = 1'b1;
          fail_n      = cnt_r[1:0] - 2'd1;
          ret_new_nxt = 1'b1;
        end else begin
          do_new  = 1'b1;
          go_tail = 1'b1;
        end
      end
      PH_NEW: begin
        do_new  = 1'b1;
        go_tail = 1'b1;
      end
      PH_REPL: begin
        if (fill_ge) begin
          do_halt = 1'b1;
        end else begin
          emit       = 1'b1;
          ev_code    = EV_BAD;
          do_consume = 1'b1;
          rep_nxt    = rep_r - 2'd1;
        end
        if (fill_ge || rep_r == 2'd1) begin
          if (ret_new_r) begin
            phase_nxt = PH_NEW;
          end else begin
            go_tail = 1'b1;
          end
        end
      end
      PH_ECR: begin
        cr_nxt = 1'b0;
        if (fill_ge) begin
          do_halt = 1'b1;
        end else begin
          do_consume = 1'b1;
        end
        go_tail = 1'b1;
      end
      PH_EFL: begin
        do_fail     = 1'b1;
        fail_n      = cnt_r[1:0] - 2'd1;
        ret_new_nxt = 1'b0;
      end
      PH_END: begin
        emit       = 1'b1;
        ev_code    = EV_END;
        cr_nxt     = 1'b0;
        cnt_nxt    = 3'd0;
        len_nxt    = 3'd0;
        cp_nxt     = 21'd0;
        pos_nxt    = 32'd0;
        line_nxt   = 24'd1;
        col_nxt    = 24'd1;
        fill_nxt   = 20'd0;
        stop_nxt   = 1'b0;
        final_step = 1'b1;
      end
      default: begin
        phase_nxt = PH_BYTE;
      end
    endcase

    if (do_new && !stop_r) begin
      priority if (head.is_cr) begin
        cr_nxt = 1'b1;
      end else if (!head.is_lf && fill_ge) begin
        do_halt = 1'b1;
      end else if (head.is_nul) begin
        emit       = 1'b1;
        ev_code    = EV_NUL;
        do_consume = 1'b1;
      end else if (head.is_ascii) begin
        if (head.is_lf) begin
          pos_nxt  = pos_r + 32'd1;
          line_nxt = (line_r != SAT24) ? line_r + 24'd1 : line_r;
          col_nxt  = 24'd1;
          fill_nxt = 20'd0;
        end else begin
          do_consume = 1'b1;
        end
      end else if (head.lead_len != 3'd0) begin
        len_nxt = head.lead_len;
        cp_nxt  = {16'd0, head.lead_bits};
        cnt_nxt = 3'd1;
      end else begin
        emit       = 1'b1;
        ev_code    = EV_BAD;
        do_consume = 1'b1;
      end
    end

    if (do_fail) begin
      emit       = 1'b1;
      ev_code    = EV_BAD;
      do_consume = 1'b1;
      cnt_nxt    = 3'd0;
      len_nxt    = 3'd0;
      cp_nxt     = 21'd0;
      rep_nxt    = fail_n;
      if (fail_n != 2'd0) begin
        phase_nxt = PH_REPL;
      end else if (ret_new_nxt) begin
        phase_nxt = PH_NEW;
      end else begin
        go_tail = 1'b1;
      end
    end

    if (do_consume) begin
      pos_nxt  = pos_r + 32'd1;
      col_nxt  = col_bump;
      fill_nxt = fill_r + 20'd1;
    end

    if (do_halt) begin
      emit     = 1'b1;
      ev_code  = EV_LONG;
      ev_off   = pos_r - {12'd0, fill_r};
      stop_nxt = 1'b1;
    end

    // after the byte: end-of-text work, or the item is done
    if (go_tail) begin
      priority if (!head.eot) begin
        final_step = 1'b1;
      end else if (!stop_nxt && cr_nxt) begin
        phase_nxt = PH_ECR;
      end else if (!stop_nxt && cnt_nxt != 3'd0) begin
        phase_nxt = PH_EFL;
      end else begin
        phase_nxt = PH_END;
      end
    end

    if (final_step) begin
      phase_nxt = (cr_nxt && !stop_nxt) ? PH_CR : PH_BYTE;
    end
  end

  assign cur_res = '{ev: ev_code, offset: ev_off, line: line_r, col: col_r, last: 1'b1};

  // a result waits in pend until it is known whether another follows
  assign flush     = pend_valid_r && pend_final_r;
  assign step_en   = head_valid && !flush;
  assign need_push = pend_valid_r ? (emit || final_step) : (emit && final_step);
  assign out_free  = !out_valid_r || res_ready;
  assign commit    = step_en && (!need_push || out_free);
  assign head_pop  = commit && final_step;
  assign load_out  = (flush && out_free) || (commit && need_push);

  always_comb begin
    out_d = cur_res;
    if (flush) begin
      out_d      = pend_r;
      out_d.last = 1'b1;
    end else if (pend_valid_r) begin
      out_d      = pend_r;
      out_d.last = !emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_BYTE;
      cr_r         <= 1'b0;
      cnt_r        <= 3'd0;
      len_r        <= 3'd0;
      cp_r         <= 21'd0;
      pos_r        <= 32'd0;
      line_r       <= 24'd1;
      col_r        <= 24'd1;
      fill_r       <= 20'd0;
      stop_r       <= 1'b0;
      rep_r        <= 2'd0;
      ret_new_r    <= 1'b0;
      pend_valid_r <= 1'b0;
      pend_final_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (commit) begin
        phase_r   <= phase_nxt;
        cr_r      <= cr_nxt;
        cnt_r     <= cnt_nxt;
        len_r     <= len_nxt;
        cp_r      <= cp_nxt;
        pos_r     <= pos_nxt;
        line_r    <= line_nxt;
        col_r     <= col_nxt;
        fill_r    <= fill_nxt;
        stop_r    <= stop_nxt;
        rep_r     <= rep_nxt;
        ret_new_r <= ret_new_nxt;
      end
      if (flush && out_free) begin
        pend_valid_r <= 1'b0;
        pend_final_r <= 1'b0;
      end else if (commit) begin
        if (emit) begin
          if (pend_valid_r || !final_step) begin
            pend_valid_r <= 1'b1;
            pend_final_r <= pend_valid_r && final_step;
          end
        end else if (final_step) begin
          pend_valid_r <= 1'b0;
        end
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit && emit && (pend_valid_r || !final_step)) begin
      pend_r <= cur_res;
    end
    if (load_out) begin
      out_r <= out_d;
    end
  end

  assign res_valid = out_valid_r;
  assign res       = out_r;

endmodule

[hdl/utf8_validator_line_tracker.sv]
// An item that gives one result passes through the queue and the out register to out_.
// Throughput: one byte per cycle when out_ does not stall; a byte after a CR also passes the
// CR state, a failed sequence adds a replay state per replayed byte (and the byte that broke it
// is taken anew), end of text adds its own states, and a byte giving several results a flush step.
// Reset (rst_n low, synchronous): queue emptied, counters to line 1 column 1,
// line byte limit to 4096.
module utf8_validator_line_tracker #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // text_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // byte_offset[31:0], line_number[55:32], column_number[79:56]
  output logic [1:0]  out_tuser,  // event_code
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [19:0] cfg_data
);
  import uvlt_pkg::*;

  logic [19:0] limit_r;
  logic        head_valid, head_pop;
  uvlt_item_t  head;
  uvlt_res_t   res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit_r <= cfg_data;
    end
  end

  uvlt_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop)
  );

  uvlt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .limit      (limit_r),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res        (res)
  );

  assign out_tdata = {res.col, res.line, res.offset};
  assign out_tuser = res.ev;
  assign out_tlast = res.last;

endmodule
